// ===== sv/tre_pkg.sv =====
// tre_pkg: shared types and constants of the tiny risc instruction executor
package tre_pkg;

   localparam int OP_BITS      = 4;
   localparam int REG_IDX_BITS = 3;
   localparam int IMM_BITS     = 32;
   localparam int PC_BITS      = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 4'h0,
      OP_SUB   = 4'h1,
      OP_AND   = 4'h2,
      OP_OR    = 4'h3,
      OP_NOT   = 4'h4,
      OP_MOV   = 4'h5,
      OP_LOAD  = 4'h6,
      OP_STORE = 4'h7,
      OP_JMP   = 4'h8,
      OP_BEQ   = 4'h9,
      OP_HALT  = 4'hF
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

endpackage

// ===== sv/tre_ram.sv =====
// tre_ram: generic simple dual-port ram with registered read
module tre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tiny_risc_instruction_executor_unit.sv =====
// tiny_risc_instruction_executor_unit: executes one decoded instruction per request
//
// usage
//   request channel (req_*): one already-fetched instruction per request:
//   opcode, destination, two source indexes and a 32-bit immediate
//   result channel (rsp_*): one result per request, in order: next pc,
//   register write report, flags, branch, halted and error marks
//   path: an accepted request is captured into the execute stage with its
//   register file / data memory read, then executed into the result register
//   throughput: one request per cycle unless the result side stalls; operands and
//   load data come from synchronous rams, and a write-back in the same cycle as the
//   next read is forwarded, so back-to-back dependent instructions need no bubble
//   reset: synchronous, active high; clears pc, flags, halted mark and the
//   register valid bits, then sweeps the data memory to zero, one word per
//   cycle, over all MEM_WORDS words while req_ready stays low
//   stall: when a waiting result meets rsp_ready low the result register holds,
//   the execute stage holds with its ram data, and req_ready drops until space frees
//   after halt every request is answered with the held pc and halted set
module tiny_risc_instruction_executor_unit #(
   parameter int REG_COUNT = 8,
   parameter int MEM_WORDS = 256,
   parameter int WORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tre_pkg::OP_BITS-1:0]           req_opcode,
   input  logic [tre_pkg::REG_IDX_BITS-1:0]      req_dest_reg,
   input  logic [tre_pkg::REG_IDX_BITS-1:0]      req_src_reg_a,
   input  logic [tre_pkg::REG_IDX_BITS-1:0]      req_src_reg_b,
   input  logic signed [tre_pkg::IMM_BITS-1:0]   req_immediate,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tre_pkg::PC_BITS-1:0]    rsp_next_pc,
   output logic                                  rsp_reg_written,
   output logic [tre_pkg::REG_IDX_BITS-1:0]      rsp_written_reg,
   output logic signed [31:0]                    rsp_written_value,
   output logic                                  rsp_zero_flag,
   output logic                                  rsp_negative_flag,
   output logic                                  rsp_branch_taken,
   output logic                                  rsp_halted,
   output logic                                  rsp_mem_error,
   output logic                                  rsp_unknown_op
);

   import tre_pkg::*;

   localparam int RA = $clog2(REG_COUNT);
   localparam int MA = $clog2(MEM_WORDS);

   // ---------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic [MA-1:0] clr_addr_ff, clr_addr_in;

   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic halt_ff, halt_in;
   logic zero_ff, zero_in;
   logic neg_ff, neg_in;
   logic [REG_COUNT-1:0] rf_vld_ff, rf_vld_in;

   // execute stage (ram data arrives here)
   logic                    s1_valid_ff, s1_valid_in;
   logic [OP_BITS-1:0]      s1_op_ff;
   logic [REG_IDX_BITS-1:0] s1_rd_ff;
   logic                    s1_rd_ok_ff;
   logic [RA-1:0]           s1_rd_idx_ff;
   logic signed [IMM_BITS-1:0] s1_imm_ff;
   logic                    s1_a_vld_ff, s1_b_vld_ff;
   logic                    s1_mem_ok_ff;
   logic [MA-1:0]           s1_maddr_ff;
   // forwarding of a write-back that landed on the same edge as the read
   logic                    fwd_a_ff, fwd_b_ff, fwd_m_ff;
   logic [WORD_BITS-1:0]    fwd_reg_data_ff, fwd_mem_data_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PC_BITS-1:0]      rsp_next_pc_ff;
   logic                    rsp_reg_written_ff;
   logic [REG_IDX_BITS-1:0] rsp_written_reg_ff;
   logic [31:0]             rsp_written_value_ff;
   logic                    rsp_zero_ff, rsp_neg_ff, rsp_taken_ff;
   logic                    rsp_halted_ff, rsp_merr_ff, rsp_unk_ff;

   // ---------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------
   logic s1_adv, accept, commit;

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RUN) && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign commit    = s1_valid_ff && s1_adv;

   // ---------------------------------------------------------------
   // read side: index decode for the incoming request
   // ---------------------------------------------------------------
   logic [RA-1:0] req_a_idx, req_b_idx, req_d_idx;
   logic          req_a_ok, req_b_ok, req_d_ok;
   logic [MA-1:0] req_maddr;
   logic          req_mem_ok;

   assign req_a_idx  = RA'(req_src_reg_a);
   assign req_b_idx  = RA'(req_src_reg_b);
   assign req_d_idx  = RA'(req_dest_reg);
   assign req_a_ok   = 32'(req_src_reg_a) < REG_COUNT;
   assign req_b_ok   = 32'(req_src_reg_b) < REG_COUNT;
   assign req_d_ok   = 32'(req_dest_reg) < REG_COUNT;
   // negative addresses look huge as unsigned, so one compare covers both ends
   assign req_mem_ok = $unsigned(req_immediate) < 32'(MEM_WORDS);
   assign req_maddr  = MA'($unsigned(req_immediate));

   // ---------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------
   logic                 rf_we;
   logic [RA-1:0]        rf_waddr;
   logic [WORD_BITS-1:0] rf_wdata;
   logic [WORD_BITS-1:0] rf_q_a, rf_q_b;

   logic                 dm_exec_we, dm_we;
   logic [MA-1:0]        dm_waddr;
   logic [WORD_BITS-1:0] dm_wdata, dm_exec_wdata;
   logic [WORD_BITS-1:0] dm_q;

   // two copies of the register file give two read ports
   tre_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (req_a_idx),
      .rd_data (rf_q_a)
   );

   tre_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (req_b_idx),
      .rd_data (rf_q_b)
   );

   // data memory, shared write port between the clearing sweep and stores
   assign dm_we    = (state_ff == ST_CLEAR) || dm_exec_we;
   assign dm_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : s1_maddr_ff;
   assign dm_wdata = (state_ff == ST_CLEAR) ? '0 : dm_exec_wdata;

   tre_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (accept),
      .rd_addr (req_maddr),
      .rd_data (dm_q)
   );

   // ---------------------------------------------------------------
   // execute
   // ---------------------------------------------------------------
   opcode_type           op_e;
   logic [WORD_BITS-1:0] opa, opb, ld_data, val;
   logic                 wr_req, alu, taken, merr, unk, do_store, do_halt, pc_inc;
   logic signed [63:0]   imm_ext;
   logic [WORD_BITS-1:0] imm_word;
   logic signed [WORD_BITS-1:0] val_s;
   logic signed [63:0]   val_ext;
   logic                 wr;
   logic [PC_BITS-1:0]   next_pc;

   assign op_e     = opcode_type'(s1_op_ff);
   assign imm_ext  = 64'(s1_imm_ff);
   assign imm_word = imm_ext[WORD_BITS-1:0];

   // operand select: forwarded write-back, else ram data, else reset value
   assign opa     = fwd_a_ff ? fwd_reg_data_ff : (s1_a_vld_ff ? rf_q_a : '0);
   assign opb     = fwd_b_ff ? fwd_reg_data_ff : (s1_b_vld_ff ? rf_q_b : '0);
   assign ld_data = fwd_m_ff ? fwd_mem_data_ff : dm_q;

   always_comb begin
      val      = '0;
      wr_req   = 1'b0;
      alu      = 1'b0;
      taken    = 1'b0;
      merr     = 1'b0;
      unk      = 1'b0;
      do_store = 1'b0;
      do_halt  = 1'b0;
      pc_inc   = 1'b0;
      if (!halt_ff) begin
         case (op_e)
            OP_ADD: begin
               val = opa + opb;
               alu = 1'b1;
            end
            OP_SUB: begin
               val = opa - opb;
               alu = 1'b1;
            end
            OP_AND: begin
               val = opa & opb;
               alu = 1'b1;
            end
            OP_OR: begin
               val = opa | opb;
               alu = 1'b1;
            end
            OP_NOT: begin
               val = ~opa;
               alu = 1'b1;
            end
            OP_MOV: begin
               val    = imm_word;
               wr_req = 1'b1;
            end
            OP_LOAD: begin
               val    = s1_mem_ok_ff ? ld_data : '0;
               merr   = !s1_mem_ok_ff;
               wr_req = 1'b1;
            end
            OP_STORE: begin
               do_store = s1_mem_ok_ff;
               merr     = !s1_mem_ok_ff;
            end
            OP_JMP: begin
               taken = 1'b1;
            end
            OP_BEQ: begin
               taken = (opa == opb);
            end
            OP_HALT: begin
               do_halt = 1'b1;
            end
            default: begin
               // unassigned opcodes behave as an alu op with a zero result
               alu = 1'b1;
               unk = 1'b1;
            end
         endcase
         pc_inc = !taken && !do_halt;
      end
   end

   assign wr    = (wr_req || alu) && s1_rd_ok_ff;
   assign val_s = val;
   assign val_ext = 64'(val_s);

   always_comb begin
      if (taken) begin
         next_pc = $unsigned(s1_imm_ff);
      end else if (pc_inc) begin
         next_pc = pc_ff + 1'b1;
      end else begin
         next_pc = pc_ff;
      end
   end

   assign rf_we         = commit && wr;
   assign rf_waddr      = s1_rd_idx_ff;
   assign rf_wdata      = val;
   assign dm_exec_we    = commit && do_store;
   assign dm_exec_wdata = opa;

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == MA'(MEM_WORDS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      pc_in     = commit ? next_pc : pc_ff;
      halt_in   = halt_ff || (commit && do_halt);
      zero_in   = (commit && alu) ? (val == '0) : zero_ff;
      neg_in    = (commit && alu) ? val[WORD_BITS-1] : neg_ff;
      rf_vld_in = rf_vld_ff;
      if (rf_we) begin
         rf_vld_in[rf_waddr] = 1'b1;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         rf_vld_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         zero_ff      <= zero_in;
         neg_ff       <= neg_in;
         rf_vld_ff    <= rf_vld_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // execute stage payload, captured with the ram read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff        <= req_opcode;
         s1_rd_ff        <= req_dest_reg;
         s1_rd_ok_ff     <= req_d_ok;
         s1_rd_idx_ff    <= req_d_idx;
         s1_imm_ff       <= req_immediate;
         s1_a_vld_ff     <= req_a_ok && rf_vld_ff[req_a_idx];
         s1_b_vld_ff     <= req_b_ok && rf_vld_ff[req_b_idx];
         s1_mem_ok_ff    <= req_mem_ok;
         s1_maddr_ff     <= req_maddr;
         fwd_a_ff        <= rf_we && req_a_ok && (rf_waddr == req_a_idx);
         fwd_b_ff        <= rf_we && req_b_ok && (rf_waddr == req_b_idx);
         fwd_m_ff        <= dm_exec_we && req_mem_ok && (s1_maddr_ff == req_maddr);
         fwd_reg_data_ff <= rf_wdata;
         fwd_mem_data_ff <= dm_exec_wdata;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_next_pc_ff       <= next_pc;
         rsp_reg_written_ff   <= wr;
         rsp_written_reg_ff   <= wr ? s1_rd_ff : '0;
         rsp_written_value_ff <= wr ? val_ext[31:0] : '0;
         rsp_zero_ff          <= zero_in;
         rsp_neg_ff           <= neg_in;
         rsp_taken_ff         <= taken;
         rsp_halted_ff        <= halt_in;
         rsp_merr_ff          <= merr;
         rsp_unk_ff           <= unk;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;
   assign rsp_reg_written   = rsp_reg_written_ff;
   assign rsp_written_reg   = rsp_written_reg_ff;
   assign rsp_written_value = rsp_written_value_ff;
   assign rsp_zero_flag     = rsp_zero_ff;
   assign rsp_negative_flag = rsp_neg_ff;
   assign rsp_branch_taken  = rsp_taken_ff;
   assign rsp_halted        = rsp_halted_ff;
   assign rsp_mem_error     = rsp_merr_ff;
   assign rsp_unknown_op    = rsp_unk_ff;

`ifndef NO_ASSERTIONS
   // no request is taken while the data memory is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request accepted during memory clear");

   // the halted mark is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halted mark dropped");

   // once halted, no architectural write reaches the memories
   a_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !rf_we && !dm_exec_we)
      else $error("write while halted");

   // every register write-back produces a result in the next cycle
   a_wb_has_rsp: assert property (@(posedge clock) disable iff (reset)
      rf_we |=> rsp_valid_ff)
      else $error("write-back without result");

   // a stalled execute stage is never overwritten
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !accept)
      else $error("execute stage overwritten while stalled");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for the tiny risc instruction executor unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tre_pkg::*;

   localparam int REG_DEPTH = 8;
   localparam int MEM_DEPTH = 256;
   localparam int MEM_ADDR_BITS = $clog2(MEM_DEPTH);

   // opcodes outside the instruction set, executed as an alu op with result 0
   localparam logic [OP_BITS-1:0] OP_UNK_LO = 4'hA;
   localparam logic [OP_BITS-1:0] OP_UNK_HI = 4'hE;

   // idle margin after the final drain
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [2:0]  written_reg;
      logic [31:0] written_value;
      logic        zero_flag;
      logic        negative_flag;
      logic        branch_taken;
      logic        halted;
      logic        mem_error;
      logic        unknown_op;
   } exec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid     = 1'b0;
   logic                    req_ready;
   logic [OP_BITS-1:0]      req_opcode    = '0;
   logic [REG_IDX_BITS-1:0] req_dest_reg  = '0;
   logic [REG_IDX_BITS-1:0] req_src_reg_a = '0;
   logic [REG_IDX_BITS-1:0] req_src_reg_b = '0;
   logic [IMM_BITS-1:0]     req_immediate = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PC_BITS-1:0]      rsp_next_pc;
   logic                    rsp_reg_written;
   logic [REG_IDX_BITS-1:0] rsp_written_reg;
   logic [31:0]             rsp_written_value;
   logic                    rsp_zero_flag;
   logic                    rsp_negative_flag;
   logic                    rsp_branch_taken;
   logic                    rsp_halted;
   logic                    rsp_mem_error;
   logic                    rsp_unknown_op;

   tiny_risc_instruction_executor_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_dest_reg      (req_dest_reg),
      .req_src_reg_a     (req_src_reg_a),
      .req_src_reg_b     (req_src_reg_b),
      .req_immediate     (req_immediate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_written_reg   (rsp_written_reg),
      .rsp_written_value (rsp_written_value),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_negative_flag (rsp_negative_flag),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_halted        (rsp_halted),
      .rsp_mem_error     (rsp_mem_error),
      .rsp_unknown_op    (rsp_unknown_op)
   );

   // architectural state of the predictor
   logic [31:0] arch_regs [REG_DEPTH];
   logic [31:0] arch_mem  [MEM_DEPTH];
   logic [31:0] arch_pc;
   logic        arch_halted;
   logic        arch_zero;
   logic        arch_neg;

   exec_result_type pending_results [$];
   int fail_count = 0;

   // idling controls, switched per test
   bit req_idle_on  = 1'b0;
   bit rsp_stall_on = 1'b0;
   int stall_left   = 0;

   // coverage tallies for the summary
   int n_req = 0, n_alu = 0, n_unknown = 0, n_mem = 0, n_mem_err = 0;
   int n_taken = 0, n_after_halt = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // generous fixed limit, well above the slowest legal run
   initial begin
      #10_000_000;
      $display("tiny_risc_instruction_executor_unit verification failed");
      $finish;
   end

   // executes one instruction on the architectural state, returns its result
   function automatic exec_result_type execute_instr(input logic [OP_BITS-1:0] op,
                                                     input logic [2:0] rd,
                                                     input logic [2:0] ra,
                                                     input logic [2:0] rb,
                                                     input logic [31:0] imm);
      exec_result_type r;
      logic [31:0] a, b, val, nxt;
      logic wr, alu, in_range;
      r        = '0;
      a        = arch_regs[ra];
      b        = arch_regs[rb];
      val      = '0;
      wr       = 1'b0;
      alu      = 1'b0;
      nxt      = arch_pc + 32'd1;
      in_range = imm < MEM_DEPTH;
      n_req++;
      if (arch_halted) begin
         // halted: nothing changes, only pc, flags and the halted mark report
         n_after_halt++;
         r.next_pc       = arch_pc;
         r.zero_flag     = arch_zero;
         r.negative_flag = arch_neg;
         r.halted        = 1'b1;
         return r;
      end
      case (op)
         OP_ADD: begin val = a + b; alu = 1'b1; end
         OP_SUB: begin val = a - b; alu = 1'b1; end
         OP_AND: begin val = a & b; alu = 1'b1; end
         OP_OR:  begin val = a | b; alu = 1'b1; end
         OP_NOT: begin val = ~a;    alu = 1'b1; end
         OP_MOV: begin val = imm;   wr = 1'b1; end
         OP_LOAD: begin
            n_mem++;
            wr = 1'b1;
            if (in_range) val = arch_mem[imm[MEM_ADDR_BITS-1:0]];
            else r.mem_error = 1'b1;
         end
         OP_STORE: begin
            n_mem++;
            if (in_range) arch_mem[imm[MEM_ADDR_BITS-1:0]] = a;
            else r.mem_error = 1'b1;
         end
         OP_JMP: begin
            nxt = imm;
            r.branch_taken = 1'b1;
         end
         OP_BEQ: begin
            if (a == b) begin
               nxt = imm;
               r.branch_taken = 1'b1;
            end
         end
         OP_HALT: begin
            nxt = arch_pc;
            arch_halted = 1'b1;
         end
         default: begin
            // unknown opcode: alu op with a zero result
            alu = 1'b1;
            r.unknown_op = 1'b1;
            n_unknown++;
         end
      endcase
      if (alu) begin
         n_alu++;
         wr        = 1'b1;
         arch_zero = (val == 32'd0);
         arch_neg  = val[31];
      end
      if (wr) begin
         arch_regs[rd]   = val;
         r.reg_written   = 1'b1;
         r.written_reg   = rd;
         r.written_value = val;
      end
      if (r.mem_error) n_mem_err++;
      if (r.branch_taken) n_taken++;
      arch_pc         = nxt;
      r.next_pc       = nxt;
      r.zero_flag     = arch_zero;
      r.negative_flag = arch_neg;
      r.halted        = arch_halted;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!req_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // drives one request, waits for its acceptance, then predicts its result.
   // called at a rising edge, returns at the accepting edge with valid still high
   task automatic issue_instr(input logic [OP_BITS-1:0] op, input logic [2:0] rd,
                              input logic [2:0] ra, input logic [2:0] rb,
                              input logic [31:0] imm);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_dest_reg  <= rd;
      req_src_reg_a <= ra;
      req_src_reg_b <= rb;
      req_immediate <= imm;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(execute_instr(op, rd, ra, rb, imm));
   endtask

   // sender pauses until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         default: return 32'h0;
      endcase
   endfunction

   // mostly a few hot words so loads see earlier stores, some misses
   function automatic logic [31:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 15);
      if (r < 85) return $urandom_range(0, MEM_DEPTH - 1);
      if (r < 90) return MEM_DEPTH + $urandom_range(0, 1000);
      if (r < 95) return -$urandom_range(1, 1000);
      return $urandom;
   endfunction

   task automatic issue_random_instr();
      int r;
      logic [OP_BITS-1:0] op;
      logic [2:0] rd, ra, rb;
      logic [31:0] imm;
      r   = $urandom_range(0, 99);
      rd  = 3'($urandom_range(0, 7));
      ra  = 3'($urandom_range(0, 7));
      rb  = 3'($urandom_range(0, 7));
      imm = $urandom;
      if (r < 40) begin
         op = OP_BITS'($urandom_range(OP_ADD, OP_NOT));
      end else if (r < 52) begin
         op = OP_MOV;
         case ($urandom_range(0, 3))
            0, 1: imm = $urandom_range(0, 15);
            2: imm = pick_extreme();
            default: ;
         endcase
      end else if (r < 66) begin
         op  = OP_LOAD;
         imm = pick_address();
      end else if (r < 80) begin
         op  = OP_STORE;
         imm = pick_address();
      end else if (r < 86) begin
         op = OP_JMP;
      end else if (r < 94) begin
         op = OP_BEQ;
         if ($urandom_range(0, 99) < 40) rb = ra;
      end else begin
         op = OP_BITS'($urandom_range(OP_UNK_LO, OP_UNK_HI));
      end
      issue_instr(op, rd, ra, rb, imm);
   endtask

   // every alu operation, mov and both unknown-opcode ends, with wrap and sign extremes
   task automatic test_alu_ops();
      issue_instr(OP_MOV, 3'd1, 3'd0, 3'd0, 32'h7FFF_FFFF);
      issue_instr(OP_MOV, 3'd2, 3'd0, 3'd0, 32'h8000_0000);
      issue_instr(OP_MOV, 3'd3, 3'd0, 3'd0, 32'hFFFF_FFFF);
      issue_instr(OP_MOV, 3'd0, 3'd7, 3'd7, 32'h0000_0001);
      issue_instr(OP_ADD, 3'd4, 3'd1, 3'd0, 32'hFFFF_FFFF);  // signed overflow
      issue_instr(OP_ADD, 3'd5, 3'd3, 3'd0, 32'h0);          // wraps to zero
      issue_instr(OP_SUB, 3'd6, 3'd2, 3'd0, 32'h0);
      issue_instr(OP_SUB, 3'd7, 3'd1, 3'd1, 32'h0);
      issue_instr(OP_AND, 3'd4, 3'd3, 3'd2, 32'h0);
      issue_instr(OP_OR,  3'd5, 3'd1, 3'd2, 32'h0);
      issue_instr(OP_NOT, 3'd6, 3'd3, 3'd0, 32'h0);
      issue_instr(OP_UNK_LO, 3'd7, 3'd3, 3'd3, 32'hA5A5_A5A5);
      issue_instr(OP_UNK_HI, 3'd0, 3'd1, 3'd2, 32'h5A5A_5A5A);
   endtask

   // stores and loads at both ends of memory and outside it
   task automatic test_memory();
      issue_instr(OP_STORE, 3'd0, 3'd1, 3'd0, 32'd0);
      issue_instr(OP_STORE, 3'd0, 3'd3, 3'd0, MEM_DEPTH - 1);
      issue_instr(OP_LOAD,  3'd2, 3'd0, 3'd0, MEM_DEPTH - 1);
      issue_instr(OP_LOAD,  3'd4, 3'd0, 3'd0, 32'd0);
      issue_instr(OP_LOAD,  3'd5, 3'd0, 3'd0, MEM_DEPTH);
      issue_instr(OP_LOAD,  3'd6, 3'd0, 3'd0, 32'hFFFF_FFFF);
      issue_instr(OP_STORE, 3'd0, 3'd1, 3'd0, 32'h7FFF_FFFF);
      issue_instr(OP_STORE, 3'd0, 3'd2, 3'd0, 32'h8000_0000);
   endtask

   // jumps, pc wrap and both outcomes of the equal branch
   task automatic test_control_flow();
      issue_instr(OP_JMP, 3'd0, 3'd0, 3'd0, 32'hFFFF_FFFF);
      issue_instr(OP_MOV, 3'd1, 3'd0, 3'd0, 32'd5);          // pc wraps to zero
      issue_instr(OP_BEQ, 3'd0, 3'd1, 3'd1, 32'h8000_0000);
      issue_instr(OP_BEQ, 3'd0, 3'd1, 3'd0, 32'h1234_5678);
      issue_instr(OP_JMP, 3'd0, 3'd0, 3'd0, 32'h0);
   endtask

   // dense dependent traffic with no idling on either side
   task automatic test_random_back_to_back(input int count);
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      repeat (count) issue_random_instr();
   endtask

   // random traffic with sender gaps and receiver stalls in changing stretches
   task automatic test_random_with_idling(input int count);
      for (int i = 0; i < count; i++) begin
         req_idle_on  = ((i / 100) % 3) != 2;
         rsp_stall_on = ((i / 100) % 3) != 1;
         issue_random_instr();
      end
   endtask

   // halt freezes everything, later requests only report the held state
   task automatic test_halt();
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      issue_instr(OP_HALT, 3'd0, 3'd0, 3'd0, 32'h0);
      issue_instr(OP_ADD,   3'd1, 3'd2, 3'd3, 32'h0);
      issue_instr(OP_STORE, 3'd0, 3'd1, 3'd0, 32'd0);
      issue_instr(OP_JMP,   3'd0, 3'd0, 3'd0, 32'h0000_0010);
      issue_instr(OP_HALT,  3'd0, 3'd0, 3'd0, 32'h0);
      issue_instr(OP_UNK_LO, 3'd4, 3'd0, 3'd0, 32'hFFFF_FFFF);
   endtask

   // receiver: random stalls, most short and a few long
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      exec_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no pending request");
            fail_count++;
         end else begin
            exp_r = pending_results.pop_front();
            check_field("next_pc",       exp_r.next_pc,       rsp_next_pc);
            check_field("reg_written",   32'(exp_r.reg_written),
                        32'(rsp_reg_written));
            check_field("written_reg",   32'(exp_r.written_reg),
                        32'(rsp_written_reg));
            check_field("written_value", exp_r.written_value, rsp_written_value);
            check_field("zero_flag",     32'(exp_r.zero_flag),
                        32'(rsp_zero_flag));
            check_field("negative_flag", 32'(exp_r.negative_flag),
                        32'(rsp_negative_flag));
            check_field("branch_taken",  32'(exp_r.branch_taken),
                        32'(rsp_branch_taken));
            check_field("halted",        32'(exp_r.halted),
                        32'(rsp_halted));
            check_field("mem_error",     32'(exp_r.mem_error),
                        32'(rsp_mem_error));
            check_field("unknown_op",    32'(exp_r.unknown_op),
                        32'(rsp_unknown_op));
         end
      end
   end

   initial begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (arch_mem[i]) arch_mem[i] = '0;
      arch_pc     = '0;
      arch_halted = 1'b0;
      arch_zero   = 1'b0;
      arch_neg    = 1'b0;

      // reset once; the memory clearing sweep is covered by waiting on req_ready
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_alu_ops();
      drain_results();
      test_memory();
      drain_results();
      test_control_flow();
      drain_results();
      test_random_back_to_back(300);
      drain_results();
      test_random_with_idling(900);
      drain_results();
      test_halt();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests: %0d alu (%0d unknown opcode), %0d memory",
               n_req, n_alu, n_unknown, n_mem);
      $display("%0d memory outside range, %0d branches taken, %0d answered while halted",
               n_mem_err, n_taken, n_after_halt);
      if (fail_count == 0) begin
         $display("tiny_risc_instruction_executor_unit verification clean");
      end else begin
         $display("tiny_risc_instruction_executor_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tre_pkg.sv
sv/tre_ram.sv
sv/tiny_risc_instruction_executor_unit.sv
tb/tb.sv
